>>> sv/dstb_pkg.sv
// Shared types and codes for the delay slot timer bank.
`timescale 1ns / 1ps
`default_nettype none

package dstb_pkg;

    // Request function codes
    typedef enum logic [0:0] {
        FUNC_POLL  = 1'b0,
        FUNC_RESET = 1'b1
    } func_t;

    // Decoded request held while the slot entry is read back
    typedef struct packed {
        func_t func;
        logic  in_range;
    } req_t;

    // Update decision returned to the controller
    typedef struct packed {
        logic we;
        logic done;
    } upd_t;

endpackage

`default_nettype wire

>>> sv/dstb_mem.sv
// Slot entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dstb_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 17
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/dstb_update.sv
// Next-entry logic for one slot: arm, count down, expire or reset.
`timescale 1ns / 1ps
`default_nettype none

module dstb_update #(
    parameter int COUNT_BITS = 16
) (
    input  wire dstb_pkg::req_t        req,
    input  wire logic [COUNT_BITS-1:0] cycles,
    input  wire logic [COUNT_BITS:0]   rd_entry,
    output logic      [COUNT_BITS:0]   wr_entry,
    output dstb_pkg::upd_t             upd
);

    logic                  armed;
    logic [COUNT_BITS-1:0] rem;

    assign armed = rd_entry[COUNT_BITS];
    assign rem   = rd_entry[COUNT_BITS-1:0];

    always_comb begin
        wr_entry = rd_entry;
        upd.we   = req.in_range;
        upd.done = 1'b0;
        if (req.in_range) begin
            case (req.func)
                dstb_pkg::FUNC_RESET: begin
                    wr_entry = '0;
                end
                default: begin
                    if (!armed) begin
                        wr_entry = {1'b1, cycles};
                    end else if (rem != '0) begin
                        wr_entry = {1'b1, rem - COUNT_BITS'(1)};
                    end else begin
                        // expired: disarm, count stays at zero
                        wr_entry = {1'b0, rem};
                        upd.done = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/delay_slot_timer_bank.sv
// Top level of the delay slot timer bank: controller, slot memory and output register.
`timescale 1ns / 1ps
`default_nettype none

// A bank of SLOTS delay slots, each an armed flag and a COUNT_BITS down-counter,
// kept together in one synchronous memory word. A poll transaction on an idle
// slot arms it with s_cycles and answers 0; on an armed slot it counts down and
// answers 0, or, once the count is zero, disarms the slot and answers 1. A reset
// transaction disarms the slot and answers 0. Slot indices of SLOTS or more leave
// all state alone and answer 0. Every input transaction yields exactly one result.
// Each transaction first reads the slot entry (registered memory read), then
// computes the new entry and writes it back; the bank takes no new transaction
// until the last one is written back. Only one transaction is in the
// read-modify-write loop at a time, so back-to-back hits on the same slot always
// see the written-back entry. The result sits in an output register, so a new
// transaction is taken while an earlier result waits on m_ready; the write-back
// stalls only if a second result is ready before the first is taken.
// After reset a clearing pass writes every slot disarmed, one slot a cycle:
// s_ready stays low until the pass has written the last slot.
module delay_slot_timer_bank #(
    parameter int SLOTS      = 256,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [7:0]  s_slot,
    input  wire logic [15:0] s_cycles,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_done_res
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int ENTRY_W = COUNT_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clear_cnt_reg;
    logic              m_valid_reg;
    logic              m_done_res_reg;

    // request held across the read
    dstb_pkg::req_t          req_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic [COUNT_BITS-1:0]   cycles_reg;

    logic [31:0]             slot_ext;
    logic [31:0]             cycles_ext;
    logic                    in_range;
    logic                    accept;
    logic                    exec_fire;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic [ENTRY_W-1:0]      mem_rdata;
    logic [ENTRY_W-1:0]      upd_entry;
    dstb_pkg::upd_t          upd;

    // widen the fixed-width ports so any SLOTS / COUNT_BITS fits
    assign slot_ext   = 32'(s_slot);
    assign cycles_ext = 32'(s_cycles);
    assign in_range   = slot_ext < 32'(SLOTS);

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    // write-back needs room in the output register
    assign exec_fire  = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    assign m_valid    = m_valid_reg;
    assign m_done_res = m_done_res_reg;

    // clearing pass owns the write port until it finishes
    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = exec_fire && upd.we;
            mem_waddr = addr_reg;
            mem_wdata = upd_entry;
        end
    end

    dstb_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (slot_ext[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    dstb_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .req      (req_reg),
        .cycles   (cycles_reg),
        .rd_entry (mem_rdata),
        .wr_entry (upd_entry),
        .upd      (upd)
    );

    // request capture, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.func     <= dstb_pkg::func_t'(s_func);
            req_reg.in_range <= in_range;
            addr_reg         <= slot_ext[IDX_W-1:0];
            cycles_reg       <= cycles_ext[COUNT_BITS-1:0];
        end
    end

    // controller and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (exec_fire) begin
                m_valid_reg    <= 1'b1;
                m_done_res_reg <= upd.done;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
                    if (clear_cnt_reg == LAST_SLOT) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always moves on to the write-back cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not reach write-back");

    // a new result only appears out of a write-back cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised without a write-back");

    // out-of-range slots never write the memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && !req_reg.in_range) |-> !mem_we)
        else $error("memory written for an out-of-range slot");

    // expiry is only ever reported for a poll
    assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && upd.done) |-> (req_reg.func == dstb_pkg::FUNC_POLL))
        else $error("done reported for a reset transaction");

    // write-back never overwrites a result still waiting on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_done_res_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
